@@ rtl/gsb_pkg.sv @@
// ----------------------------------------------------------------------------
// gsb_pkg
// Shared types and constants of the gyro stillness and bias detector.
// ----------------------------------------------------------------------------
package gsb_pkg;

  localparam int THR_W     = 16;
  localparam int MARGIN_W  = 11;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH    = 2'd0,
    CFG_QUIET_THRESHOLD  = 2'd1,
    CFG_CALIBRATE_ENABLE = 2'd2
  } cfg_reg_t;

  typedef logic [1:0] axis_t;

  localparam axis_t AXIS_X    = 2'd0;
  localparam axis_t AXIS_Y    = 2'd1;
  localparam axis_t AXIS_Z    = 2'd2;
  localparam axis_t AXIS_LAST = AXIS_Z;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_RANGE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  // per-axis range margin in Q8: 3.0, 6.5 and 7.0
  function automatic logic [MARGIN_W-1:0] axis_margin(input axis_t axis);
    logic [MARGIN_W-1:0] m;
    case (axis)
      AXIS_X:  m = 11'd768;
      AXIS_Y:  m = 11'd1664;
      AXIS_Z:  m = 11'd1792;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/gsb_in_if.sv @@
// ----------------------------------------------------------------------------
// gsb_in_if
// Sample channel: valid/ready handshake carrying one three-axis rate sample.
// ----------------------------------------------------------------------------
interface gsb_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] rate_x;
  logic signed [SAMPLE_WIDTH-1:0] rate_y;
  logic signed [SAMPLE_WIDTH-1:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

@@ rtl/gsb_out_if.sv @@
// ----------------------------------------------------------------------------
// gsb_out_if
// Result channel: valid/ready handshake carrying one window verdict.
// ----------------------------------------------------------------------------
interface gsb_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic                           is_quiet;
  logic                           offsets_valid;
  logic signed [SAMPLE_WIDTH-1:0] bias_x;
  logic signed [SAMPLE_WIDTH-1:0] bias_y;
  logic signed [SAMPLE_WIDTH-1:0] bias_z;

  modport source (output valid, output is_quiet, output offsets_valid,
                  output bias_x, output bias_y, output bias_z, input ready);
  modport sink   (input valid, input is_quiet, input offsets_valid,
                  input bias_x, input bias_y, input bias_z, output ready);
endinterface

@@ rtl/gyro_stillness_bias_detector.sv @@
// ----------------------------------------------------------------------------
// gyro_stillness_bias_detector
// Windowed stillness test on three-axis gyro rates with zero-rate bias
// estimate (negated window mean) from a shared bit-serial divider.
// ----------------------------------------------------------------------------
//  port     direction  transfer moves
//  in_ch    sink       rate_x, rate_y, rate_z
//  out_ch   source     is_quiet, offsets_valid, bias_x, bias_y, bias_z
//  cfg_*    write      window_length, quiet_threshold, calibrate_enable
//
//  a sample is accepted by the transfer, then updated one axis at a time
//  through the shared compare/add unit; no new sample is taken meanwhile.
//  a window-ending sample adds a range check per axis, then a divider load
//  and bit-serial run per axis when offsets are computed, then the emit step.
//  the result sits in an output register; a stalled result only holds back
//  the next window end, not the samples before it.
//  synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module gyro_stillness_bias_detector #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 12,
  localparam int CfgW = (COUNT_WIDTH > gsb_pkg::THR_W) ? COUNT_WIDTH : gsb_pkg::THR_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CfgW-1:0]                cfg_wdata,
  gsb_in_if.sink                         in_ch,
  gsb_out_if.source                      out_ch
);
  import gsb_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COUNT_WIDTH;
  localparam int SUMW = SW + CW;
  localparam int DCW  = $clog2(SUMW);
  localparam int RngW = SW + 1;

  // configuration
  logic [CW-1:0]    win_len_r;
  logic [THR_W-1:0] thr_r;
  logic             cal_en_r;

  // control
  state_t          state_r, state_nxt;
  axis_t           axis_r, axis_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   taken_r, taken_nxt;
  logic            quiet_r, quiet_nxt;
  logic [DCW-1:0]  cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  // datapath
  logic [SW-1:0]   samp_r [3];
  logic [SW-1:0]   samp_nxt [3];
  logic [SW-1:0]   max_r [3];
  logic [SW-1:0]   max_nxt [3];
  logic [SW-1:0]   min_r [3];
  logic [SW-1:0]   min_nxt [3];
  logic [SUMW-1:0] sum_r [3];
  logic [SUMW-1:0] sum_nxt [3];
  logic [SW-1:0]   bias_r [3];
  logic [SW-1:0]   bias_nxt [3];
  logic [SUMW-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic            neg_r, neg_nxt;
  logic            out_quiet_r, out_quiet_nxt;
  logic            out_offs_r, out_offs_nxt;
  logic [SW-1:0]   out_bias_r [3];
  logic [SW-1:0]   out_bias_nxt [3];

  // shared unit
  logic [SW-1:0]   s_cur, max_cur, min_cur;
  logic [SUMW-1:0] sum_cur, sum_add, sum_mag;
  logic            first, s_gt, s_lt;
  logic [CW:0]     taken, len_eff;
  logic [RngW-1:0] rng, limit;
  logic            in_limit;
  logic [CW:0]     rem_sh, rem_sub;
  logic            div_ge;
  logic [SUMW-1:0] quo;
  logic [SW-1:0]   bias_res;
  logic            out_hold;

  assign s_cur   = samp_r[axis_r];
  assign max_cur = max_r[axis_r];
  assign min_cur = min_r[axis_r];
  assign sum_cur = sum_r[axis_r];

  assign first   = (idx_r == '0);
  assign s_gt    = $signed(s_cur) > $signed(max_cur);
  assign s_lt    = $signed(s_cur) < $signed(min_cur);
  assign sum_add = sum_cur + {{CW{s_cur[SW-1]}}, s_cur};

  assign taken   = (CW+1)'(idx_r) + (CW+1)'(1);
  assign len_eff = (win_len_r == '0) ? (CW+1)'(1) : (CW+1)'(win_len_r);

  // max >= min, so the range is nonnegative and compares unsigned
  assign rng      = {max_cur[SW-1], max_cur} - {min_cur[SW-1], min_cur};
  assign limit    = RngW'(thr_r) + RngW'(axis_margin(axis_r));
  assign in_limit = rng < limit;

  assign sum_mag = sum_cur[SUMW-1] ? (SUMW'(0) - sum_cur) : sum_cur;

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[SUMW-1]};
  assign div_ge  = rem_sh >= (CW+1)'(taken_r);
  assign rem_sub = rem_sh - (CW+1)'(taken_r);
  assign quo     = {dvd_r[SUMW-2:0], div_ge};

  // negative sum gives positive bias, which can hit +2^(SW-1) and saturates
  always_comb begin
    if (neg_r) begin
      if (|quo[SUMW-1:SW-1]) begin
        bias_res = {1'b0, {(SW-1){1'b1}}};
      end else begin
        bias_res = quo[SW-1:0];
      end
    end else begin
      bias_res = SW'(0) - quo[SW-1:0];
    end
  end

  assign out_hold    = out_valid_r && !out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    idx_nxt       = idx_r;
    taken_nxt     = taken_r;
    quiet_nxt     = quiet_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_hold;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    out_quiet_nxt = out_quiet_r;
    out_offs_nxt  = out_offs_r;
    samp_nxt      = samp_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    sum_nxt       = sum_r;
    bias_nxt      = bias_r;
    out_bias_nxt  = out_bias_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          samp_nxt[0] = in_ch.rate_x;
          samp_nxt[1] = in_ch.rate_y;
          samp_nxt[2] = in_ch.rate_z;
          axis_nxt    = AXIS_X;
          state_nxt   = ST_ACC;
        end
      end
      ST_ACC: begin
        max_nxt[axis_r] = (first || s_gt) ? s_cur : max_cur;
        min_nxt[axis_r] = (first || s_lt) ? s_cur : min_cur;
        sum_nxt[axis_r] = sum_add;
        if (axis_r == AXIS_LAST) begin
          axis_nxt = AXIS_X;
          if (taken < len_eff) begin
            idx_nxt   = taken[CW-1:0];
            state_nxt = ST_IDLE;
          end else begin
            taken_nxt = taken[CW-1:0];
            quiet_nxt = 1'b1;
            state_nxt = ST_RANGE;
          end
        end else begin
          axis_nxt = axis_r + axis_t'(1);
        end
      end
      ST_RANGE: begin
        quiet_nxt = quiet_r && in_limit;
        if (axis_r == AXIS_LAST) begin
          axis_nxt  = AXIS_X;
          state_nxt = (quiet_r && in_limit && cal_en_r) ? ST_DIV_LOAD : ST_EMIT;
        end else begin
          axis_nxt = axis_r + axis_t'(1);
        end
      end
      ST_DIV_LOAD: begin
        dvd_nxt   = sum_mag;
        neg_nxt   = sum_cur[SUMW-1];
        rem_nxt   = '0;
        cnt_nxt   = DCW'(SUMW - 1);
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        dvd_nxt = quo;
        rem_nxt = div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
        cnt_nxt = cnt_r - DCW'(1);
        if (cnt_r == '0) begin
          bias_nxt[axis_r] = bias_res;
          if (axis_r == AXIS_LAST) begin
            axis_nxt  = AXIS_X;
            state_nxt = ST_EMIT;
          end else begin
            axis_nxt  = axis_r + axis_t'(1);
            state_nxt = ST_DIV_LOAD;
          end
        end
      end
      ST_EMIT: begin
        if (!out_hold) begin
          out_valid_nxt = 1'b1;
          out_quiet_nxt = quiet_r;
          out_offs_nxt  = quiet_r && cal_en_r;
          for (int a = 0; a < 3; a++) begin
            out_bias_nxt[a] = (quiet_r && cal_en_r) ? bias_r[a] : '0;
            sum_nxt[a]      = '0;
          end
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= CW'(500);
      thr_r     <= '0;
      cal_en_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:    win_len_r <= cfg_wdata[CW-1:0];
        CFG_QUIET_THRESHOLD:  thr_r     <= cfg_wdata[THR_W-1:0];
        CFG_CALIBRATE_ENABLE: cal_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= AXIS_X;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        sum_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    taken_r     <= taken_nxt;
    quiet_r     <= quiet_nxt;
    cnt_r       <= cnt_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    neg_r       <= neg_nxt;
    out_quiet_r <= out_quiet_nxt;
    out_offs_r  <= out_offs_nxt;
    samp_r      <= samp_nxt;
    max_r       <= max_nxt;
    min_r       <= min_nxt;
    bias_r      <= bias_nxt;
    out_bias_r  <= out_bias_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.is_quiet      = out_quiet_r;
  assign out_ch.offsets_valid = out_offs_r;
  assign out_ch.bias_x        = out_bias_r[0];
  assign out_ch.bias_y        = out_bias_r[1];
  assign out_ch.bias_z        = out_bias_r[2];

  a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_ACC && axis_r == AXIS_X)
    else $error("accepted sample did not start the axis update");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result raised outside the emit step");

  a_offsets_need_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_offs_r |-> out_quiet_r)
    else $error("offsets flagged on a window that is not quiet");

  a_bias_zero_without_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_offs_r |->
      out_bias_r[0] == '0 && out_bias_r[1] == '0 && out_bias_r[2] == '0)
    else $error("nonzero bias without offsets");

  a_divider_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_RUN && cnt_r != '0 |=> state_r == ST_DIV_RUN)
    else $error("divider left before its last quotient bit");

endmodule
